FILE: rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int DefMaxTracks = 16;

  localparam int CountW = 5;
  localparam int CodeW  = 4;
  localparam int ModeW  = 2;
  localparam int TrackOutW = 4;

  localparam logic [CountW-1:0] TrackCountRst = 5'd14;

  // player mode codes, as seen on player_mode
  localparam logic [ModeW-1:0] ModePaused  = 2'd0;
  localparam logic [ModeW-1:0] ModeStopped = 2'd1;
  localparam logic [ModeW-1:0] ModePlaying = 2'd2;

  // button codes, active low
  localparam logic [CodeW-1:0] CodeReleased = 4'hF;
  localparam logic [CodeW-1:0] CodePrev     = 4'd7;
  localparam logic [CodeW-1:0] CodeStop     = 4'd11;
  localparam logic [CodeW-1:0] CodeToggle   = 4'd13;
  localparam logic [CodeW-1:0] CodeNext     = 4'd14;

  localparam logic OpSample   = 1'b0;
  localparam logic OpTrackEnd = 1'b1;

  typedef struct packed {
    logic             held;
    logic [CodeW-1:0] code;
    logic [ModeW-1:0] mode;
  } bpc_state_t;

  typedef struct packed {
    logic reload;
    logic applied;
  } bpc_flags_t;

endpackage

FILE: rtl/bpc_in_if.sv
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] button_sample;

  modport source (output valid, output op, output button_sample, input ready);
  modport sink (input valid, input op, input button_sample, output ready);
endinterface

FILE: rtl/bpc_out_if.sv
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] player_mode;
  logic [3:0] track_number;
  logic       reload_track;
  logic       command_applied;
  logic       button_held;

  modport source (
    output valid, output player_mode, output track_number, output reload_track,
    output command_applied, output button_held, input ready
  );
  modport sink (
    input valid, input player_mode, input track_number, input reload_track,
    input command_applied, input button_held, output ready
  );
endinterface

FILE: rtl/bpc_step.sv
module bpc_step #(
  parameter int MAX_TRACKS = bpc_pkg::DefMaxTracks,
  localparam int TW = $clog2(MAX_TRACKS)
) (
  input  logic [bpc_pkg::CountW-1:0] track_count_i,
  input  logic                       op_i,
  input  logic [bpc_pkg::CodeW-1:0]  sample_i,
  input  bpc_pkg::bpc_state_t        state_i,
  input  logic [TW-1:0]              track_i,
  output bpc_pkg::bpc_state_t        state_o,
  output logic [TW-1:0]              track_o,
  output bpc_pkg::bpc_flags_t        flags_o
);
  import bpc_pkg::*;

  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int NW = (CW > CountW) ? CW : CountW;

  logic [NW-1:0]    count_ext;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    track_ext;
  logic [NW-1:0]    track_inc;
  logic [TW-1:0]    track_prev;
  logic [TW-1:0]    track_next;
  logic [ModeW-1:0] mode_keep;

  // clamp the track count to 1..MAX_TRACKS
  always_comb begin
    count_ext = NW'(track_count_i);
    if (count_ext == '0) begin
      n_eff = NW'(1);
    end else if (count_ext > NW'(MAX_TRACKS)) begin
      n_eff = NW'(MAX_TRACKS);
    end else begin
      n_eff = count_ext;
    end
  end

  assign track_ext  = NW'(track_i);
  assign track_inc  = track_ext + NW'(1);
  assign track_prev = (track_i == '0) ? TW'(n_eff - NW'(1)) : track_i - TW'(1);
  assign track_next = (track_inc >= n_eff) ? '0 : TW'(track_inc);
  assign mode_keep  = (state_i.mode == ModePlaying) ? ModePlaying : ModeStopped;

  always_comb begin
    state_o = state_i;
    track_o = track_i;
    flags_o = '0;
    if (op_i == OpTrackEnd) begin
      state_o.mode   = ModeStopped;
      flags_o.reload = 1'b1;
    end else if (!state_i.held && sample_i != CodeReleased) begin
      state_o.held = 1'b1;
      state_o.code = sample_i;
    end else if (state_i.held && sample_i == CodeReleased) begin
      state_o.held    = 1'b0;
      state_o.code    = CodeReleased;
      flags_o.applied = 1'b1;
      case (state_i.code)
        CodePrev: begin
          track_o        = track_prev;
          state_o.mode   = mode_keep;
          flags_o.reload = 1'b1;
        end
        CodeStop: begin
          state_o.mode = ModeStopped;
        end
        CodeToggle: begin
          if (state_i.mode == ModePaused || state_i.mode == ModeStopped) begin
            state_o.mode = ModePlaying;
          end else if (state_i.mode == ModePlaying) begin
            state_o.mode = ModePaused;
          end
        end
        CodeNext: begin
          track_o        = track_next;
          state_o.mode   = mode_keep;
          flags_o.reload = 1'b1;
        end
        default: begin
          // several buttons at once: no change beyond the applied pulse
        end
      endcase
    end
  end

endmodule

FILE: rtl/button_player_control.sv
// An input transfer loads its result into the output register at the same clock edge.
// Throughput: one item per cycle unless the output stalls; the player state updates
// at the input transfer, so each item sees the state left by the one before it.
// Reset (rst_ni low, asynchronous): stopped, track 0, no press held, track_count 14,
// output register empty.
module button_player_control #(
  parameter int MAX_TRACKS = bpc_pkg::DefMaxTracks
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::CountW-1:0] cfg_wdata_i,
  bpc_in_if.sink                     in_ch_i,
  bpc_out_if.source                  out_ch_o
);
  import bpc_pkg::*;

  localparam int TW  = $clog2(MAX_TRACKS);
  localparam int XW  = (TW > TrackOutW) ? TW : TrackOutW;

  logic [CountW-1:0] track_count_q;
  bpc_state_t        state_q, state_d;
  logic [TW-1:0]     track_q, track_d;
  bpc_flags_t        flags_d;

  logic              out_valid_q;
  logic [ModeW-1:0]  mode_out_q;
  logic [TrackOutW-1:0] track_out_q;
  bpc_flags_t        flags_out_q;
  logic              held_out_q;

  logic in_xfer;
  logic [XW-1:0] track_wide;

  assign in_ch_i.ready = !out_valid_q || out_ch_o.ready;
  assign in_xfer       = in_ch_i.valid && in_ch_i.ready;

  bpc_step #(
    .MAX_TRACKS(MAX_TRACKS)
  ) u_step (
    .track_count_i(track_count_q),
    .op_i         (in_ch_i.op),
    .sample_i     (in_ch_i.button_sample),
    .state_i      (state_q),
    .track_i      (track_q),
    .state_o      (state_d),
    .track_o      (track_d),
    .flags_o      (flags_d)
  );

  assign track_wide = XW'(track_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= TrackCountRst;
    end else if (cfg_we_i) begin
      track_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{held: 1'b0, code: '0, mode: ModeStopped};
      track_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
      track_q <= track_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload: load on input transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_out_q  <= state_d.mode;
      track_out_q <= track_wide[TrackOutW-1:0];
      flags_out_q <= flags_d;
      held_out_q  <= state_d.held;
    end
  end

  assign out_ch_o.valid           = out_valid_q;
  assign out_ch_o.player_mode     = mode_out_q;
  assign out_ch_o.track_number    = track_out_q;
  assign out_ch_o.reload_track    = flags_out_q.reload;
  assign out_ch_o.command_applied = flags_out_q.applied;
  assign out_ch_o.button_held     = held_out_q;

`ifndef SYNTH
  a_xfer_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("input transfer did not load the output register");

  a_track_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_ch_i.op == OpTrackEnd |=>
      flags_out_q.reload && mode_out_q == ModeStopped && !flags_out_q.applied)
    else $error("track end did not stop the player with a reload");

  a_applied_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && flags_out_q.applied |-> !held_out_q)
    else $error("applied command left a press held");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == ModePaused || state_q.mode == ModeStopped ||
    state_q.mode == ModePlaying)
    else $error("player mode register holds an unused code");
`endif

endmodule

FILE: verif/player_ctrl_checker.sv
module player_ctrl_checker #(
  parameter int MAX_TRACKS = bpc_pkg::DefMaxTracks
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::CountW-1:0] cfg_wdata_i,
  bpc_in_if                          in_ch_i,
  bpc_out_if                         out_ch_i,
  output int                         error_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int MaxPrinted = 50;

  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [TrackOutW-1:0] track;
    logic                 reload;
    logic                 applied;
    logic                 held;
  } player_result_t;

  // shadow copy of the player state
  logic [CountW-1:0] track_count_now = TrackCountRst;
  logic              press_held      = 1'b0;
  logic [CodeW-1:0]  press_code      = '0;
  logic [ModeW-1:0]  mode_now        = ModeStopped;
  int                track_idx       = 0;

  player_result_t expected_results[$];
  int             failures = 0;

  assign error_count_o = failures;

  task automatic report_failure(input string msg);
    if (failures < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    failures++;
  endtask

  function automatic player_result_t predict_player_step(input logic op,
                                                         input logic [CodeW-1:0] sample);
    player_result_t res;
    logic           reload;
    logic           applied;
    int             n_tracks;
    reload   = 1'b0;
    applied  = 1'b0;
    n_tracks = int'(track_count_now);
    if (n_tracks == 0) n_tracks = 1;
    if (n_tracks > MAX_TRACKS) n_tracks = MAX_TRACKS;

    if (op == OpTrackEnd) begin
      mode_now = ModeStopped;
      reload   = 1'b1;
    end else if (!press_held && sample != CodeReleased) begin
      press_held = 1'b1;
      press_code = sample;
    end else if (press_held && sample == CodeReleased) begin
      press_held = 1'b0;
      applied    = 1'b1;
      case (press_code)
        CodePrev: begin
          track_idx = (track_idx == 0) ? n_tracks - 1 : track_idx - 1;
          mode_now  = (mode_now == ModePlaying) ? ModePlaying : ModeStopped;
          reload    = 1'b1;
        end
        CodeStop: begin
          mode_now = ModeStopped;
        end
        CodeToggle: begin
          if (mode_now == ModePaused || mode_now == ModeStopped) mode_now = ModePlaying;
          else if (mode_now == ModePlaying) mode_now = ModePaused;
        end
        CodeNext: begin
          track_idx = (track_idx + 1 >= n_tracks) ? 0 : track_idx + 1;
          mode_now  = (mode_now == ModePlaying) ? ModePlaying : ModeStopped;
          reload    = 1'b1;
        end
        default: begin
        end
      endcase
      press_code = CodeReleased;
    end

    res.mode    = mode_now;
    res.track   = TrackOutW'(track_idx);
    res.reload  = reload;
    res.applied = applied;
    res.held    = press_held;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    player_result_t exp_res;
    if (!rst_ni) begin
      track_count_now = TrackCountRst;
      press_held      = 1'b0;
      press_code      = '0;
      mode_now        = ModeStopped;
      track_idx       = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) track_count_now = cfg_wdata_i;
      // results lag their inputs, so retire before predicting the new transfer
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (expected_results.size() == 0) begin
          report_failure("result transfer with no prediction pending");
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch_i.player_mode !== exp_res.mode)
            report_failure($sformatf("player_mode got %0d exp %0d",
                                     out_ch_i.player_mode, exp_res.mode));
          if (out_ch_i.track_number !== exp_res.track)
            report_failure($sformatf("track_number got %0d exp %0d",
                                     out_ch_i.track_number, exp_res.track));
          if (out_ch_i.reload_track !== exp_res.reload)
            report_failure($sformatf("reload_track got %0b exp %0b",
                                     out_ch_i.reload_track, exp_res.reload));
          if (out_ch_i.command_applied !== exp_res.applied)
            report_failure($sformatf("command_applied got %0b exp %0b",
                                     out_ch_i.command_applied, exp_res.applied));
          if (out_ch_i.button_held !== exp_res.held)
            report_failure($sformatf("button_held got %0b exp %0b",
                                     out_ch_i.button_held, exp_res.held));
        end
      end
      if (in_ch_i.valid && in_ch_i.ready)
        expected_results.push_back(predict_player_step(in_ch_i.op, in_ch_i.button_sample));
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int RandomItems = 900;
  localparam int Segments    = 8;
  localparam int LongHold    = 80;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  int error_count;
  int pending;
  int items_sent   = 0;
  int burst_left   = 0;
  int settings_cnt = 0;
  bit hold_req     = 1'b0;
  bit hold_seen    = 1'b0;

  button_player_control i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  player_ctrl_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // one transfer per call; burst bookkeeping decides when to drop valid
  task automatic send_item(input logic op, input logic [CodeW-1:0] sample);
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.button_sample <= sample;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic press(input logic [CodeW-1:0] code);
    send_item(OpSample, code);
    send_item(OpSample, CodeReleased);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_track_count(input logic [CountW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_cnt++;
  endtask

  // receiver: stall pattern in phases, plus one long hold-off on request
  initial begin : receiver
    int stall_pct;
    int phase_left;
    stall_pct  = 0;
    phase_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : stimulus
    int               kind;
    int               seg_end;
    logic [CodeW-1:0] code;
    logic [CountW-1:0] seg_count [Segments];
    seg_count = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd14, 5'd9};
    seg_count[7] = CountW'($urandom_range(0, 31));

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OpSample;
    in_ch.button_sample <= CodeReleased;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command, held noise, track end while held, wrap cases
    press(CodeNext);
    press(CodeToggle);
    send_item(OpSample, CodeNext);
    send_item(OpSample, CodePrev);
    send_item(OpSample, CodeReleased);
    press(CodePrev);
    press(CodeToggle);
    press(CodePrev);
    press(CodePrev);
    press(CodeStop);
    press(4'h0);
    send_item(OpSample, CodeNext);
    send_item(OpTrackEnd, 4'h0);
    send_item(OpSample, CodeReleased);
    send_item(OpTrackEnd, 4'hF);
    send_item(OpSample, CodeReleased);

    // zero count acts as one track
    write_track_count(5'd0);
    press(CodeNext);
    // count above the track limit saturates
    write_track_count(5'd31);
    press(CodePrev);
    // index left above a lowered count
    write_track_count(5'd3);
    press(CodePrev);
    press(CodeNext);

    for (int seg = 0; seg < Segments; seg++) begin
      write_track_count(seg_count[seg]);
      if (seg == 3) hold_req = ~hold_req;
      seg_end = items_sent + RandomItems / Segments;
      while (items_sent < seg_end) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          case ($urandom_range(0, 4))
            0: code = CodePrev;
            1: code = CodeStop;
            2: code = CodeToggle;
            3: code = CodeNext;
            default: code = CodeW'($urandom_range(0, 14));
          endcase
          send_item(OpSample, code);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 9) == 0) send_item(OpTrackEnd, CodeW'($urandom));
            else send_item(OpSample, CodeW'($urandom_range(0, 14)));
          end
          send_item(OpSample, CodeReleased);
        end else if (kind < 8) begin
          send_item(OpSample, CodeW'($urandom));
        end else if (kind == 8) begin
          send_item(OpTrackEnd, CodeW'($urandom));
        end else begin
          send_item(OpSample, CodeReleased);
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Drove %0d button/track-end items over %0d track_count settings,", items_sent,
             settings_cnt + 1);
    $display("with bursty input, random output stalls and one long output hold-off.");
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (error_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
